// File: hdl/resonance_frequency_sweep_search_defines.svh
// Assertion macros shared by the sweep search RTL.
`ifndef RESONANCE_FREQUENCY_SWEEP_SEARCH_DEFINES_SVH
`define RESONANCE_FREQUENCY_SWEEP_SEARCH_DEFINES_SVH

// Antecedent true implies consequent in the same cycle.
`define RFSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sweep search: same-cycle check failed");

// Antecedent true implies consequent in the following cycle.
`define RFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sweep search: next-cycle check failed");

`endif

// File: hdl/rfss_pkg.sv
package rfss_pkg;

    // Field widths of the block.
    localparam int FREQ_W   = 20;
    localparam int SAMPLE_W = 12;
    localparam int STEP_W   = 16;
    localparam int TICK_W   = 8;
    localparam int OFS_W    = 16;
    localparam int WORD_W   = FREQ_W + 2;
    localparam int DISP_W   = 17;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_UPPER_FREQ   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOWER_FREQ   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SETTLE_TICKS = 3'd3;
    localparam logic [IDX_W-1:0] REG_SAMPLE_WAIT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FINAL_OFFSET = 3'd5;
    localparam logic [IDX_W-1:0] REG_MIN_PEAK     = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]   RST_STEP_SIZE    = 16'd1;
    localparam logic [TICK_W-1:0]   RST_SETTLE_TICKS = 8'd35;
    localparam logic [TICK_W-1:0]   RST_SAMPLE_WAIT  = 8'd5;
    localparam logic [OFS_W-1:0]    RST_FINAL_OFFSET = 16'd150;
    localparam logic [SAMPLE_W-1:0] RST_MIN_PEAK     = 12'd20;

    // Reciprocal of ten scaled by 2^23, rounded up; exact for all 20-bit inputs.
    localparam int DIV10_SHIFT = 23;
    localparam logic [FREQ_W-1:0] DIV10_MAGIC = 20'd838861;
    localparam int PROD_W = 2 * FREQ_W;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SETTLE = 3'd1,
        PH_SAMPLE = 3'd2,
        PH_WAIT   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [FREQ_W-1:0]   upper_freq;
        logic [FREQ_W-1:0]   lower_freq;
        logic [STEP_W-1:0]   step_size;
        logic [TICK_W-1:0]   settle_ticks;
        logic [TICK_W-1:0]   sample_wait;
        logic [OFS_W-1:0]    final_offset;
        logic [SAMPLE_W-1:0] min_peak;
    } t_cfg;

    typedef struct packed {
        logic                cmd_valid;
        logic [WORD_W-1:0]   freq_word;
        logic                done;
        logic [FREQ_W-1:0]   best_freq;
        logic                alarm;
        logic [SAMPLE_W-1:0] peak;
    } t_result;

    // Quotient by ten through the scaled reciprocal.
    function automatic logic [DISP_W-1:0] f_div10(input logic [FREQ_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV10_MAGIC);
        return p[DIV10_SHIFT +: DISP_W];
    endfunction

endpackage

// File: hdl/rfss_core.sv
module rfss_core
    import rfss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_restart,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output t_result             o_res
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_wait, n_wait;
    logic [FREQ_W-1:0]   r_cur, n_cur;
    logic [FREQ_W-1:0]   r_best, n_best;
    logic [SAMPLE_W-1:0] r_peak, n_peak;
    logic                r_alarm, n_alarm;

    logic                w_valid;
    logic [FREQ_W-1:0]   w_cmd;
    logic [FREQ_W:0]     w_sum;
    logic [TICK_W-1:0]   w_wait_inc;
    logic [FREQ_W-1:0]   w_step;

    assign w_wait_inc = r_wait + 1'b1;
    assign w_step     = FREQ_W'(i_cfg.step_size);

    // State update for the item leaving the input register.
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_cur   = r_cur;
        n_best  = r_best;
        n_peak  = r_peak;
        n_alarm = r_alarm;
        w_valid = 1'b0;
        w_cmd   = '0;
        w_sum   = '0;
        if (i_restart || r_phase == PH_START) begin
            n_cur   = i_cfg.upper_freq;
            n_best  = '0;
            n_peak  = '0;
            n_alarm = 1'b0;
            n_wait  = '0;
            n_phase = PH_SETTLE;
            w_cmd   = i_cfg.upper_freq;
            w_valid = 1'b1;
        end else begin
            case (r_phase)
                PH_SETTLE: begin
                    if (r_wait >= i_cfg.settle_ticks) begin
                        n_wait  = '0;
                        n_phase = PH_SAMPLE;
                    end else begin
                        n_wait = w_wait_inc;
                    end
                end
                PH_SAMPLE: begin
                    if (i_sample > r_peak) begin
                        n_peak = i_sample;
                        n_best = r_cur;
                    end
                    w_valid = 1'b1;
                    if (r_cur >= i_cfg.lower_freq) begin
                        // Step down, saturating at zero.
                        n_cur   = (r_cur >= w_step) ? r_cur - w_step : '0;
                        w_cmd   = n_cur;
                        n_phase = PH_WAIT;
                    end else begin
                        // Sweep ends: add the offset with saturation and judge the result.
                        w_sum   = {1'b0, n_best} + (FREQ_W + 1)'(i_cfg.final_offset);
                        n_best  = w_sum[FREQ_W] ? '1 : w_sum[FREQ_W-1:0];
                        w_cmd   = n_best;
                        n_alarm = (n_best < i_cfg.lower_freq) || (n_peak <= i_cfg.min_peak);
                        n_phase = PH_DONE;
                    end
                end
                PH_WAIT: begin
                    if (w_wait_inc >= i_cfg.sample_wait) begin
                        n_wait  = '0;
                        n_phase = PH_SAMPLE;
                    end else begin
                        n_wait = w_wait_inc;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Result fields reflect the state after this item.
    always_comb begin
        o_res.cmd_valid = w_valid;
        o_res.freq_word = w_valid ? {w_cmd, 2'b00} : '0;
        o_res.done      = (n_phase == PH_DONE);
        o_res.best_freq = n_best;
        o_res.alarm     = n_alarm;
        o_res.peak      = n_peak;
    end

    // Sweep state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_wait  <= '0;
            r_cur   <= '0;
            r_best  <= '0;
            r_peak  <= '0;
            r_alarm <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_cur   <= n_cur;
            r_best  <= n_best;
            r_peak  <= n_peak;
            r_alarm <= n_alarm;
        end
    end

endmodule

// File: hdl/resonance_frequency_sweep_search.sv
// Resonance search by a downward frequency sweep.
// Slave stream: one beat per tick; s_tuser is the request kind (restart or
// sample tick) and s_tdata carries the feedback reading. Every accepted beat
// yields exactly one master beat with the commanded frequency (tuser flags
// whether a new frequency is commanded), the done flag, the best frequency,
// its value divided by ten, the alarm and the peak level.
// Configuration is a plain write port (enable, index, data); the user must write it only while
// the block is idle, which the block itself does not enforce; a write takes effect at the clock edge.
// A beat waits in the input register, and its result is registered in the output
// register before it appears on the master side.
// Throughput: one beat per cycle while the receiver keeps up; the per-tick state
// update is a single compare, step and saturating add between input and output registers.
// When the receiver stalls, the output register holds and the input register
// takes one more beat before s_tready falls; nothing is dropped.
// Reset (synchronous, active low) empties both registers, puts the sweep in
// the start phase and restores the configuration defaults.
module resonance_frequency_sweep_search
    import rfss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // Slave stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // [11:0] adc_sample, rest zero
    input  logic [0:0]        s_tuser,  // [0] req_type
    // Master stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,  // [21:0] freq_word, [22] sweep_done,
                                        // [42:23] best_freq, [59:43] display_freq,
                                        // [60] alarm, [72:61] peak_level, rest zero
    output logic [0:0]        m_tuser   // [0] freq_cmd_valid
);

`include "resonance_frequency_sweep_search_defines.svh"

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic                r_in_req;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;
    t_result             w_res;
    logic                w_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_freq   <= '0;
            r_cfg.lower_freq   <= '0;
            r_cfg.step_size    <= RST_STEP_SIZE;
            r_cfg.settle_ticks <= RST_SETTLE_TICKS;
            r_cfg.sample_wait  <= RST_SAMPLE_WAIT;
            r_cfg.final_offset <= RST_FINAL_OFFSET;
            r_cfg.min_peak     <= RST_MIN_PEAK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_UPPER_FREQ:   r_cfg.upper_freq   <= i_cfg_data[FREQ_W-1:0];
                REG_LOWER_FREQ:   r_cfg.lower_freq   <= i_cfg_data[FREQ_W-1:0];
                REG_STEP_SIZE:    r_cfg.step_size    <= i_cfg_data[STEP_W-1:0];
                REG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg_data[TICK_W-1:0];
                REG_SAMPLE_WAIT:  r_cfg.sample_wait  <= i_cfg_data[TICK_W-1:0];
                REG_FINAL_OFFSET: r_cfg.final_offset <= i_cfg_data[OFS_W-1:0];
                REG_MIN_PEAK:     r_cfg.min_peak     <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the item moves on when the output register is free or drains.
    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_req    <= s_tuser[0];
            r_in_sample <= s_tdata[SAMPLE_W-1:0];
        end
    end

    rfss_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_restart (r_in_req),
        .i_sample  (r_in_sample),
        .i_cfg     (r_cfg),
        .o_res     (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // Master beat packing; the display value is derived from the held best frequency.
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.cmd_valid;
    assign m_tdata  = {7'b0, r_out.peak, r_out.alarm, f_div10(r_out.best_freq),
                       r_out.best_freq, r_out.done, r_out.freq_word};

    // A restart always commands a frequency and leaves the done phase.
    `RFSS_ASSERT_NEXT(a_restart_cmd, i_clk, i_rst_n, w_adv && r_in_req,
        r_out_valid && r_out.cmd_valid && !r_out.done)
    // An advancing item always lands in the result register.
    `RFSS_ASSERT_NEXT(a_adv_lands, i_clk, i_rst_n, w_adv, r_out_valid)
    // Back-pressure only when both registers are occupied.
    `RFSS_ASSERT_SAME(a_ready_low, i_clk, i_rst_n, !s_tready, r_in_valid && r_out_valid)

endmodule

// File: sim/tb_top.sv
module tb_top;
    import rfss_pkg::*;

    // One master beat as the generator side sees it.
    typedef struct packed {
        logic                cmd_valid;
        logic [WORD_W-1:0]   word;
        logic                done;
        logic [FREQ_W-1:0]   best;
        logic [DISP_W-1:0]   disp;
        logic                alarm;
        logic [SAMPLE_W-1:0] peak;
    } t_sweep_beat;

    // Tracks the sweep from the accepted ticks and checks every master beat.
    class sweep_tracker;
        logic [FREQ_W-1:0]   upper, lower;
        logic [STEP_W-1:0]   step;
        logic [TICK_W-1:0]   settle, sample_wait;
        logic [OFS_W-1:0]    offset;
        logic [SAMPLE_W-1:0] min_peak;

        t_phase              state;
        logic [TICK_W-1:0]   wcnt;
        logic [FREQ_W-1:0]   cur, best;
        logic [SAMPLE_W-1:0] peak;
        logic                alarm;

        t_sweep_beat beats_due[$];
        int mismatches;
        int checked;

        function new();
            upper = '0;
            lower = '0;
            step = RST_STEP_SIZE;
            settle = RST_SETTLE_TICKS;
            sample_wait = RST_SAMPLE_WAIT;
            offset = RST_FINAL_OFFSET;
            min_peak = RST_MIN_PEAK;
            state = PH_START;
            wcnt = '0;
            cur = '0;
            best = '0;
            peak = '0;
            alarm = 1'b0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_UPPER_FREQ:   upper = val[FREQ_W-1:0];
                REG_LOWER_FREQ:   lower = val[FREQ_W-1:0];
                REG_STEP_SIZE:    step = val[STEP_W-1:0];
                REG_SETTLE_TICKS: settle = val[TICK_W-1:0];
                REG_SAMPLE_WAIT:  sample_wait = val[TICK_W-1:0];
                REG_FINAL_OFFSET: offset = val[OFS_W-1:0];
                REG_MIN_PEAK:     min_peak = val[SAMPLE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_done();
            return state == PH_DONE;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        // Advance the sweep by one accepted tick and queue the beat it causes.
        function void note_tick(logic restart, logic [SAMPLE_W-1:0] reading);
            t_sweep_beat beat;
            logic [FREQ_W:0] total;
            logic [FREQ_W-1:0] cmd;
            logic cmd_valid;
            cmd = '0;
            cmd_valid = 1'b0;
            if (restart || state == PH_START) begin
                cur = upper;
                best = '0;
                peak = '0;
                alarm = 1'b0;
                wcnt = '0;
                cmd = upper;
                cmd_valid = 1'b1;
                state = PH_SETTLE;
            end else begin
                case (state)
                    PH_SETTLE: begin
                        if (wcnt >= settle) begin
                            wcnt = '0;
                            state = PH_SAMPLE;
                        end else begin
                            wcnt = wcnt + 1'b1;
                        end
                    end
                    PH_SAMPLE: begin
                        if (reading > peak) begin
                            peak = reading;
                            best = cur;
                        end
                        if (cur >= lower) begin
                            // Step down, saturating at zero.
                            cur = (cur >= step) ? cur - step : '0;
                            cmd = cur;
                            cmd_valid = 1'b1;
                            state = PH_WAIT;
                        end else begin
                            // Sweep over: apply the offset, saturating at full scale.
                            total = {1'b0, best} + offset;
                            best = total[FREQ_W] ? '1 : total[FREQ_W-1:0];
                            cmd = best;
                            cmd_valid = 1'b1;
                            alarm = (best < lower) || (peak <= min_peak);
                            state = PH_DONE;
                        end
                    end
                    PH_WAIT: begin
                        wcnt = wcnt + 1'b1;
                        if (wcnt >= sample_wait) begin
                            wcnt = '0;
                            state = PH_SAMPLE;
                        end
                    end
                    default: state = PH_DONE;
                endcase
            end
            beat.cmd_valid = cmd_valid;
            beat.word = cmd_valid ? {cmd, 2'b00} : '0;
            beat.done = (state == PH_DONE);
            beat.best = best;
            beat.disp = DISP_W'(best / 10);
            beat.alarm = alarm;
            beat.peak = peak;
            beats_due.push_back(beat);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (mismatches < 10)
                    $display("beat %0d %s: expected 0x%0h, got 0x%0h",
                             checked, field, want, got);
                mismatches++;
            end
        endfunction

        // Match a master beat against the oldest queued beat.
        function void check_beat(logic cmd_valid, logic [79:0] data);
            t_sweep_beat want;
            if (beats_due.size() == 0) begin
                if (mismatches < 10)
                    $display("beat %0d arrived with nothing queued: data 0x%0h",
                             checked, data);
                mismatches++;
                checked++;
                return;
            end
            want = beats_due.pop_front();
            compare("freq_cmd_valid", want.cmd_valid, cmd_valid);
            compare("freq_word", want.word, data[21:0]);
            compare("sweep_done", want.done, data[22]);
            compare("best_freq", want.best, data[42:23]);
            compare("display_freq", want.disp, data[59:43]);
            compare("alarm", want.alarm, data[60]);
            compare("peak_level", want.peak, data[72:61]);
            checked++;
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;   // [11:0] adc_sample, rest zero
    logic [0:0]        s_tuser = '0;   // [0] req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [79:0]       m_tdata;        // [21:0] freq_word, [22] sweep_done,
                                       // [42:23] best_freq, [59:43] display_freq,
                                       // [60] alarm, [72:61] peak_level
    logic [0:0]        m_tuser;        // [0] freq_cmd_valid

    sweep_tracker sb = new();

    bit hold_req = 1'b0;
    bit gaps_on = 1'b0;
    int burst_left = 0;

    resonance_frequency_sweep_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watch both streams at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_tick(s_tuser[0], s_tdata[SAMPLE_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tuser[0], m_tdata);
        end
    end

    // Receiver: windows of free flow, light and heavy stalling, plus one long hold.
    initial begin : rx_pattern
        int left;
        int mode;
        left = 0;
        mode = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (300) begin
                    m_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge i_clk);
        end
    end

    // Offer one beat and hold it until it is taken; valid stays high afterwards.
    task automatic send_tick(input logic restart, input logic [SAMPLE_W-1:0] reading);
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= 16'(reading);
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Same, but in bursts, with idle gaps between them when gaps_on is set.
    task automatic send_paced(input logic restart, input logic [SAMPLE_W-1:0] reading);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_tick(restart, reading);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Wait until every queued beat is out, then write all registers.
    task automatic load_config(input logic [FREQ_W-1:0] up, lo,
                               input logic [STEP_W-1:0] st,
                               input logic [TICK_W-1:0] se, sw,
                               input logic [OFS_W-1:0] ofs,
                               input logic [SAMPLE_W-1:0] mp);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(REG_UPPER_FREQ, CFG_W'(up));
        write_reg(REG_LOWER_FREQ, CFG_W'(lo));
        write_reg(REG_STEP_SIZE, CFG_W'(st));
        write_reg(REG_SETTLE_TICKS, CFG_W'(se));
        write_reg(REG_SAMPLE_WAIT, CFG_W'(sw));
        write_reg(REG_FINAL_OFFSET, CFG_W'(ofs));
        write_reg(REG_MIN_PEAK, CFG_W'(mp));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A random setting followed by sweeps with random readings and, unless extreme, stray restarts.
    task automatic random_phase(input int n_items, input bit extreme, input bit squeeze);
        logic [FREQ_W-1:0] up, lo;
        logic [STEP_W-1:0] st;
        logic [TICK_W-1:0] se, sw;
        int span;
        int top;
        int k;
        bit restart;
        up = FREQ_W'($urandom);
        case ($urandom_range(0, 9))
            0: st = '0;
            1: st = '1;
            default: st = STEP_W'($urandom_range(1, 40));
        endcase
        span = int'(st) * $urandom_range(0, 6) + $urandom_range(0, 40);
        case ($urandom_range(0, 7))
            0: lo = '0;
            // A limit above the start ends the sweep on the first sample.
            1: lo = (up > 20'hFFFF0) ? '1 : up + 20'd9;
            default: lo = (up > span) ? up - FREQ_W'(span) : '0;
        endcase
        se = TICK_W'($urandom_range(0, 4));
        sw = TICK_W'($urandom_range(0, 3));
        if (extreme) begin
            up = 20'd65535;
            lo = 20'd1;
            st = '1;
            se = '1;
            sw = 8'd16;
        end
        load_config(up, lo, st, se, sw, OFS_W'($urandom), SAMPLE_W'($urandom));
        case ($urandom_range(0, 3))
            0: top = 0;
            1: top = 40;
            default: top = 4095;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
        burst_left = 0;
        if (squeeze)
            hold_req = 1'b1;
        send_paced(1'b1, SAMPLE_W'($urandom));
        for (k = 1; k < n_items; k++) begin
            restart = !extreme && ((sb.in_done() && $urandom_range(0, 3) == 0) ||
                                   $urandom_range(0, 39) == 0);
            send_paced(restart, SAMPLE_W'($urandom_range(0, top)));
        end
    endtask

    initial begin : stimulus
        int p;
        int guard;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale readings and offset; a tick out of reset starts the sweep,
        // readings in the settle and wait phases are ignored, the weak-peak alarm fires.
        load_config(20'd20, 20'd10, 16'd4, 8'd1, 8'd0, 16'hFFFF, 12'hFFF);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b1, 12'hFFF);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b0, 12'h007);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'h005);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'h003);
        send_tick(1'b0, 12'hFFF);

        // Top of the range with the largest step: the offset sum saturates.
        load_config(20'hFFFFF, 20'd1047575, 16'hFFFF, 8'd0, 8'd1, 16'hFFFF, 12'h000);
        send_tick(1'b1, 12'h000);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'h001);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'h000);

        // Start below the limit: result under the lower limit raises the alarm.
        load_config(20'd3, 20'd100, 16'hFFFF, 8'd0, 8'd0, 16'd0, 12'h000);
        send_tick(1'b1, 12'h000);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'd50);

        // Step below zero clamps, and a zero limit keeps the sweep going.
        load_config(20'd3, 20'd0, 16'hFFFF, 8'd0, 8'd0, 16'd1, 12'h000);
        send_tick(1'b1, 12'h000);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'd9);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'd9);
        send_tick(1'b0, 12'h000);
        send_tick(1'b0, 12'hABC);

        // Random settings; one phase runs against a long receiver hold.
        for (p = 0; p < 5; p++)
            random_phase(24, 1'b0, p == 3);
        // Longest settle wait, then a step to zero and the end of the sweep.
        random_phase(280, 1'b1, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (sb.pending() > 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[resonance_frequency_sweep_search] OK");
        end else begin
            $display("[resonance_frequency_sweep_search] ERROR");
        end
        $finish;
    end

    // Hard stop for a hung handshake.
    initial begin
        #(12 * 3000000);
        $display("[resonance_frequency_sweep_search] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/rfss_pkg.sv
hdl/rfss_core.sv
hdl/resonance_frequency_sweep_search.sv
sim/tb_top.sv
